/* rtl/segment_intersection_test_defines.svh */
// Assertion macros for the segment intersection test block.
// Every property runs on i_clk and is disabled while i_rst_n is low.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// consequent must hold on the cycle after the antecedent
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// consequent must hold a fixed number of cycles after the antecedent
`define SIT_ASSERT_AFTER(label, ante, delay, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(delay) (cons)) else $error(msg);

`endif

/* rtl/segint_pkg.sv */
package segint_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int TOL_W      = 16;
    localparam int LANES      = 4;
    localparam int LATENCY    = 5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic        [TOL_W-1:0]      t_tol;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_diff x;
        t_diff y;
    } t_vec;

    // seg: far end of the other segment minus its near end
    // to0, to1: this endpoint minus each end of the other segment
    typedef struct packed {
        t_vec seg;
        t_vec to0;
        t_vec to1;
    } t_lane;

    typedef struct packed {
        t_prod cxy;
        t_prod cyx;
        t_prod dxx;
        t_prod dyy;
    } t_prods;

    function automatic t_diff f_sub(input t_coord a, input t_coord b);
        t_diff ea;
        t_diff eb;
        ea = t_diff'(a);
        eb = t_diff'(b);
        return ea - eb;
    endfunction

    function automatic t_vec f_sub_pt(input t_point a, input t_point b);
        t_vec r;
        r.x = f_sub(a.x, b.x);
        r.y = f_sub(a.y, b.y);
        return r;
    endfunction

endpackage

/* rtl/segint_front.sv */
module segint_front import segint_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_point i_a0,
    input  t_point i_a1,
    input  t_point i_b0,
    input  t_point i_b1,
    output logic   o_valid,
    output t_lane  o_lane [LANES]
);

    t_point w_p  [LANES];
    t_point w_o0 [LANES];
    t_point w_o1 [LANES];
    t_lane  n_lane [LANES];
    t_lane  r_lane [LANES];
    logic   r_valid;

    // lanes: endpoint a0, a1 against segment b; b0, b1 against segment a
    assign w_p[0]  = i_a0;
    assign w_p[1]  = i_a1;
    assign w_p[2]  = i_b0;
    assign w_p[3]  = i_b1;
    assign w_o0[0] = i_b0;
    assign w_o0[1] = i_b0;
    assign w_o0[2] = i_a0;
    assign w_o0[3] = i_a0;
    assign w_o1[0] = i_b1;
    assign w_o1[1] = i_b1;
    assign w_o1[2] = i_a1;
    assign w_o1[3] = i_a1;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_lane[k].seg = f_sub_pt(w_o1[k], w_o0[k]);
            n_lane[k].to0 = f_sub_pt(w_p[k], w_o0[k]);
            n_lane[k].to1 = f_sub_pt(w_p[k], w_o1[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* rtl/segint_prod.sv */
module segint_prod import segint_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_lane i_lane [LANES],
    output logic  o_valid,
    output t_sum  o_cross [LANES],
    output t_sum  o_dot [LANES]
);

    t_prods n_prod [LANES];
    t_prods r_prod [LANES];
    t_sum   n_cross [LANES];
    t_sum   n_dot [LANES];
    t_sum   r_cross [LANES];
    t_sum   r_dot [LANES];
    logic   r_prod_valid;
    logic   r_sum_valid;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_prod[k].cxy = t_prod'(i_lane[k].seg.x) * t_prod'(i_lane[k].to0.y);
            n_prod[k].cyx = t_prod'(i_lane[k].seg.y) * t_prod'(i_lane[k].to0.x);
            n_prod[k].dxx = t_prod'(i_lane[k].to0.x) * t_prod'(i_lane[k].to1.x);
            n_prod[k].dyy = t_prod'(i_lane[k].to0.y) * t_prod'(i_lane[k].to1.y);
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_cross[k] = t_sum'(r_prod[k].cxy) - t_sum'(r_prod[k].cyx);
            n_dot[k]   = t_sum'(r_prod[k].dxx) + t_sum'(r_prod[k].dyy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
            r_sum_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_cross <= n_cross;
        r_dot   <= n_dot;
    end

    assign o_valid = r_sum_valid;
    assign o_cross = r_cross;
    assign o_dot   = r_dot;

endmodule

/* rtl/segint_decide.sv */
module segint_decide import segint_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sum i_cross [LANES],
    input  t_sum i_dot [LANES],
    input  t_tol i_tol,
    output logic o_valid,
    output logic o_meet
);

    t_sum             w_tol_pos;
    t_sum             w_tol_neg;
    logic [LANES-1:0] n_pos;
    logic [LANES-1:0] n_neg;
    logic [LANES-1:0] n_dot_le;
    logic [LANES-1:0] r_pos;
    logic [LANES-1:0] r_neg;
    logic [LANES-1:0] r_dot_le;
    logic [LANES-1:0] w_on_seg;
    logic             w_cross_a;
    logic             w_cross_b;
    logic             n_meet;
    logic             r_class_valid;
    logic             r_valid;
    logic             r_meet;

    assign w_tol_pos = t_sum'(i_tol);
    assign w_tol_neg = -w_tol_pos;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_pos[k]    = i_cross[k] > w_tol_pos;
            n_neg[k]    = i_cross[k] < w_tol_neg;
            n_dot_le[k] = i_dot[k] <= w_tol_pos;
        end
    end

    // lanes 0/1 are a0/a1 against b, lanes 2/3 are b0/b1 against a
    assign w_on_seg  = ~r_pos & ~r_neg & r_dot_le;
    assign w_cross_a = (r_pos[0] & r_neg[1]) | (r_neg[0] & r_pos[1]);
    assign w_cross_b = (r_pos[2] & r_neg[3]) | (r_neg[2] & r_pos[3]);
    assign n_meet    = (w_cross_a & w_cross_b) | (|w_on_seg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_valid <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_class_valid <= i_valid;
            r_valid       <= r_class_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_neg    <= n_neg;
        r_dot_le <= n_dot_le;
        r_meet   <= n_meet;
    end

    assign o_valid = r_valid;
    assign o_meet  = r_meet;

endmodule

/* rtl/segment_intersection_test.sv */
// Segment intersection test. Each word on start carries the endpoints of two
// closed segments; at the pipeline's end o_valid pulses for one cycle with
// o_segments_meet set when the segments share a point (crossing, touching or
// collinear overlap). busy is always low: a new word may enter every cycle,
// and the five-stage pipeline (differences, products, sums, tolerance
// classification, final decision) has no back-pressure, so the receiver must
// take every result in the cycle it appears. The tolerance register is
// written with i_cfg_we and must change only while no word is in flight.
`include "segment_intersection_test_defines.svh"

module segment_intersection_test import segint_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  logic   i_cfg_we,
    input  t_tol   i_cfg_wdata,
    input  t_coord i_a_start_x,
    input  t_coord i_a_start_y,
    input  t_coord i_a_end_x,
    input  t_coord i_a_end_y,
    input  t_coord i_b_start_x,
    input  t_coord i_b_start_y,
    input  t_coord i_b_end_x,
    input  t_coord i_b_end_y,
    output logic   o_valid,
    output logic   o_segments_meet
);

    t_tol   r_tol;
    t_point w_a0;
    t_point w_a1;
    t_point w_b0;
    t_point w_b1;
    logic   w_take;
    logic   w_front_valid;
    t_lane  w_lane [LANES];
    logic   w_prod_valid;
    t_sum   w_cross [LANES];
    t_sum   w_dot [LANES];
    logic   w_all_same;

    assign busy   = 1'b0;
    assign w_take = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    assign w_a0 = '{x: i_a_start_x, y: i_a_start_y};
    assign w_a1 = '{x: i_a_end_x,   y: i_a_end_y};
    assign w_b0 = '{x: i_b_start_x, y: i_b_start_y};
    assign w_b1 = '{x: i_b_end_x,   y: i_b_end_y};

    segint_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_take),
        .i_a0    (w_a0),
        .i_a1    (w_a1),
        .i_b0    (w_b0),
        .i_b1    (w_b1),
        .o_valid (w_front_valid),
        .o_lane  (w_lane)
    );

    segint_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .i_lane  (w_lane),
        .o_valid (w_prod_valid),
        .o_cross (w_cross),
        .o_dot   (w_dot)
    );

    segint_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .i_cross (w_cross),
        .i_dot   (w_dot),
        .i_tol   (r_tol),
        .o_valid (o_valid),
        .o_meet  (o_segments_meet)
    );

    assign w_all_same = (w_a0 == w_a1) && (w_a0 == w_b0) && (w_a0 == w_b1);

    `SIT_ASSERT_NEXT(a_take_enters, w_take, w_front_valid, "accepted word did not enter pipeline")
    `SIT_ASSERT_AFTER(a_word_out, w_take, LATENCY, o_valid, "accepted word produced no result")
    `SIT_ASSERT_AFTER(a_no_ghost, !w_take, LATENCY, !o_valid, "result without an accepted word")
    `SIT_ASSERT_AFTER(a_point_meets, w_take && w_all_same, LATENCY, o_segments_meet, "coincident points reported apart")

endmodule
